@@ sv/snu_pkg.sv @@
`timescale 1ns / 1ps

package snu_pkg;

  localparam int WordW     = 60;
  localparam int CoefW     = 48;
  localparam int BexpW     = 12;
  localparam int ExpW      = 18;
  localparam int CntW      = 6;
  localparam int ChunkW    = 6;
  localparam int NumChunks = CoefW / ChunkW;
  localparam int LzW       = 3;
  localparam int EadjW     = 13;
  localparam int EfinW     = 14;

  localparam logic [CntW-1:0]       WORD_BITS  = CntW'(WordW);
  localparam logic [CntW-1:0]       COEF_BITS  = CntW'(CoefW);
  localparam logic [10:0]           EXP_FLIP   = 11'o2000;
  localparam logic [ExpW-1:0]       EXP_BIAS   = 18'o2000;
  localparam logic [9:0]            EXP_SPEC   = 10'o1777;
  localparam logic signed [EadjW-1:0] BIAS_S13 = 13'sd1024;
  localparam logic signed [EfinW-1:0] BIAS_S14 = 14'sd1024;

  typedef enum logic [2:0] {
    OP_ROTL   = 3'd0,
    OP_SRA    = 3'd1,
    OP_PACK   = 3'd2,
    OP_UNPACK = 3'd3,
    OP_NORM   = 3'd4,
    OP_MASK   = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]       func;
    logic [WordW-1:0] data_word;
    logic [CntW-1:0]  shift_amount;
    logic [ExpW-1:0]  exponent_in;
    logic             round_enable;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] result_word;
    logic [ExpW-1:0]  exponent_out;
    logic [CntW-1:0]  norm_shift;
  } out_t;

  typedef struct packed {
    op_t                             op;
    logic [WordW-1:0]                word;
    logic [CntW-1:0]                 amt;
    logic                            fill;
    logic [WordW-1:0]                simple_res;
    logic [ExpW-1:0]                 exp_out;
    logic [CoefW-1:0]                coef;
    logic signed [EadjW-1:0]         e_adj;
    logic                            norm_pass;
    logic                            norm_zero;
    logic                            rnd;
    logic [NumChunks-1:0]            chunk_zero;
    logic [NumChunks-1:0][LzW-1:0]   chunk_lz;
  } s1_t;

  typedef struct packed {
    logic                    norm_live;
    logic                    fill;
    logic [WordW-1:0]        hi;
    logic [WordW-1:0]        lo;
    logic [CntW-1:0]         rsh;
    logic signed [EadjW-1:0] e_adj;
    logic [ExpW-1:0]         exp_out;
    logic [CntW-1:0]         norm_shift;
  } s2_t;

  function automatic logic [LzW-1:0] lz6(input logic [ChunkW-1:0] v);
    logic [LzW-1:0] n;
    logic           hit;
    n   = LzW'(ChunkW);
    hit = 1'b0;
    for (int i = ChunkW - 1; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = LzW'(ChunkW - 1 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

@@ sv/snu_decode.sv @@
`timescale 1ns / 1ps

module snu_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic          in_vld,
  input  snu_pkg::in_t  in_beat,
  output logic          s1_valid_r,
  output snu_pkg::s1_t  s1_r
);

  snu_pkg::s1_t                       s1_nxt;
  snu_pkg::op_t                       op;
  logic                               fill;
  logic [snu_pkg::WordW-1:0]          wf;
  logic [snu_pkg::BexpW-1:0]          e12;
  logic signed [snu_pkg::EadjW-1:0]   t;
  logic [snu_pkg::CntW-1:0]           n;

  always_comb begin
    op   = snu_pkg::op_t'(in_beat.func);
    n    = in_beat.shift_amount;
    fill = in_beat.data_word[snu_pkg::WordW-1];
    wf   = in_beat.data_word ^ {snu_pkg::WordW{fill}};
    e12  = wf[snu_pkg::WordW-1:snu_pkg::CoefW];

    s1_nxt            = '0;
    s1_nxt.op         = op;
    s1_nxt.word       = in_beat.data_word;
    s1_nxt.fill       = fill;
    s1_nxt.coef       = wf[snu_pkg::CoefW-1:0];
    s1_nxt.rnd        = in_beat.round_enable;
    s1_nxt.norm_pass  = (e12[9:0] == snu_pkg::EXP_SPEC);
    s1_nxt.norm_zero  = !in_beat.round_enable && (wf[snu_pkg::CoefW-1:0] == '0);

    unique case (op)
      snu_pkg::OP_ROTL: begin
        s1_nxt.amt = (n >= snu_pkg::WORD_BITS) ? n - snu_pkg::WORD_BITS : n;
      end
      snu_pkg::OP_SRA, snu_pkg::OP_MASK: begin
        s1_nxt.amt = (n > snu_pkg::WORD_BITS) ? snu_pkg::WORD_BITS : n;
      end
      default: begin
        s1_nxt.amt = n;
      end
    endcase

    unique case (op)
      snu_pkg::OP_PACK: begin
        s1_nxt.simple_res = {1'b0, in_beat.exponent_in[10:0] ^ snu_pkg::EXP_FLIP,
                             wf[snu_pkg::CoefW-1:0]} ^ {snu_pkg::WordW{fill}};
      end
      snu_pkg::OP_UNPACK: begin
        s1_nxt.simple_res = {{(snu_pkg::WordW - snu_pkg::CoefW){1'b0}},
                             wf[snu_pkg::CoefW-1:0]} ^ {snu_pkg::WordW{fill}};
        s1_nxt.exp_out    = {{(snu_pkg::ExpW - snu_pkg::BexpW){1'b0}}, e12}
                            - snu_pkg::EXP_BIAS;
      end
      default: begin
        s1_nxt.simple_res = '0;
      end
    endcase

    // ones' complement unbias
    t = $signed({1'b0, e12}) - snu_pkg::BIAS_S13;
    if (t < 0) begin
      t = t + 13'sd1;
    end
    s1_nxt.e_adj = t;

    for (int k = 0; k < snu_pkg::NumChunks; k++) begin
      s1_nxt.chunk_zero[k] =
        (wf[snu_pkg::CoefW-1-snu_pkg::ChunkW*k -: snu_pkg::ChunkW] == '0);
      s1_nxt.chunk_lz[k]   =
        snu_pkg::lz6(wf[snu_pkg::CoefW-1-snu_pkg::ChunkW*k -: snu_pkg::ChunkW]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

@@ sv/snu_setup.sv @@
`timescale 1ns / 1ps

module snu_setup (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic          s1_valid,
  input  snu_pkg::s1_t  s1,
  output logic          s2_valid_r,
  output snu_pkg::s2_t  s2_r
);

  snu_pkg::s2_t             s2_nxt;
  logic [snu_pkg::CntW-1:0] cnt;
  logic                     found;

  always_comb begin
    // leading zero count from per-chunk results
    cnt   = snu_pkg::COEF_BITS;
    found = 1'b0;
    for (int k = 0; k < snu_pkg::NumChunks; k++) begin
      if (!found && !s1.chunk_zero[k]) begin
        cnt   = snu_pkg::CntW'(k * snu_pkg::ChunkW) + snu_pkg::CntW'(s1.chunk_lz[k]);
        found = 1'b1;
      end
    end

    s2_nxt         = '0;
    s2_nxt.fill    = s1.fill;
    s2_nxt.e_adj   = s1.e_adj;
    s2_nxt.exp_out = s1.exp_out;
    s2_nxt.rsh     = snu_pkg::WORD_BITS;

    unique case (s1.op)
      snu_pkg::OP_ROTL: begin
        s2_nxt.hi  = s1.word;
        s2_nxt.lo  = s1.word;
        s2_nxt.rsh = snu_pkg::WORD_BITS - s1.amt;
      end
      snu_pkg::OP_SRA: begin
        s2_nxt.hi  = {snu_pkg::WordW{s1.fill}};
        s2_nxt.lo  = s1.word;
        s2_nxt.rsh = s1.amt;
      end
      snu_pkg::OP_MASK: begin
        s2_nxt.hi  = '1;
        s2_nxt.rsh = s1.amt;
      end
      snu_pkg::OP_NORM: begin
        priority if (s1.norm_pass) begin
          s2_nxt.hi = s1.word;
        end else if (s1.norm_zero) begin
          s2_nxt.norm_shift = snu_pkg::COEF_BITS;
        end else begin
          s2_nxt.hi         = {{(snu_pkg::WordW - snu_pkg::CoefW){1'b0}}, s1.coef};
          s2_nxt.lo         = {s1.rnd, {(snu_pkg::WordW - 1){1'b0}}};
          s2_nxt.rsh        = snu_pkg::WORD_BITS - cnt;
          s2_nxt.norm_shift = cnt;
          s2_nxt.norm_live  = 1'b1;
        end
      end
      default: begin
        s2_nxt.hi = s1.simple_res;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

@@ sv/snu_shift.sv @@
`timescale 1ns / 1ps

module snu_shift (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic          s2_valid,
  input  snu_pkg::s2_t  s2,
  output logic          out_valid_r,
  output snu_pkg::out_t out_r
);

  snu_pkg::out_t                     out_nxt;
  logic [2*snu_pkg::WordW-1:0]       cat;
  logic [snu_pkg::WordW-1:0]         f;
  logic signed [snu_pkg::EfinW-1:0]  u;

  always_comb begin
    // funnel shift
    cat = {s2.hi, s2.lo} >> s2.rsh;
    f   = cat[snu_pkg::WordW-1:0];

    // ones' complement exponent adjust and rebias
    u = snu_pkg::EfinW'($signed(s2.e_adj)) - $signed({1'b0, s2.norm_shift});
    if (u < 0) begin
      u = u - 14'sd1;
    end
    u = u + snu_pkg::BIAS_S14;

    out_nxt              = '0;
    out_nxt.exponent_out = s2.exp_out;
    out_nxt.norm_shift   = s2.norm_shift;
    if (s2.norm_live) begin
      if (u < 0) begin
        out_nxt.result_word = '0;
      end else begin
        out_nxt.result_word = {u[snu_pkg::BexpW-1:0], f[snu_pkg::CoefW-1:0]}
                              ^ {snu_pkg::WordW{s2.fill}};
      end
    end else begin
      out_nxt.result_word = f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

endmodule

@@ sv/sixty_bit_shift_normalize_unit.sv @@
// throughput: one beat per cycle while the result side does not stall,
// three register stages (decode and chunk zero count, count merge and
// shift setup, funnel shift and exponent fix)
// a stall on the result side holds every stage in place
// reset: synchronous active-low rst_n clears all stage valid bits
`timescale 1ns / 1ps

module sixty_bit_shift_normalize_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  snu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output snu_pkg::out_t out_data
);

  logic         advance;
  logic         s1_valid;
  logic         s2_valid;
  snu_pkg::s1_t s1;
  snu_pkg::s2_t s2;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  snu_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .in_vld     (in_valid),
    .in_beat    (in_data),
    .s1_valid_r (s1_valid),
    .s1_r       (s1)
  );

  snu_setup u_setup (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .s2_valid_r (s2_valid),
    .s2_r       (s2)
  );

  snu_shift u_shift (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .s2_valid    (s2_valid),
    .s2          (s2),
    .out_valid_r (out_valid),
    .out_r       (out_data)
  );

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.norm_shift <= snu_pkg::COEF_BITS)
    else $error("norm shift out of range");

  a_exp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.exponent_out != '0 |-> out_data.norm_shift == '0)
    else $error("unpack exponent with normalize count");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted beat lost at first stage");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(s1_valid) && $stable(s2_valid))
    else $error("pipeline moved during stall");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam logic [2:0] OP_SPARE6   = 3'd6;
  localparam logic [2:0] OP_SPARE7   = 3'd7;
  localparam int         HOLD_CYCLES = 300;
  localparam int         CYCLE_LIMIT = 400000;

  class shift_result_board;
    snu_pkg::out_t awaited[$];
    int            mismatches;

    function snu_pkg::out_t shifted_result(snu_pkg::in_t b);
      snu_pkg::out_t res;
      logic [59:0] d, s, w;
      logic [119:0] wide;
      logic [47:0] c;
      logic [11:0] be;
      logic [5:0]  n;
      int          ee, cnt;
      res = '0;
      d   = b.data_word;
      n   = b.shift_amount;
      s   = {60{d[59]}};
      w   = d ^ s;
      case (b.func)
        snu_pkg::OP_ROTL: begin
          if (n >= 60) n = n - 6'd60;
          wide = {d, d} >> (60 - n);
          res.result_word = wide[59:0];
        end
        snu_pkg::OP_SRA: begin
          if (n > 60) n = 6'd60;
          wide = {s, d} >> n;
          res.result_word = wide[59:0];
        end
        snu_pkg::OP_PACK: begin
          res.result_word = {1'b0, b.exponent_in[10:0] ^ 11'o2000, w[47:0]} ^ s;
        end
        snu_pkg::OP_UNPACK: begin
          res.exponent_out = {6'd0, w[59:48]} - 18'o2000;
          res.result_word  = {12'd0, w[47:0]} ^ s;
        end
        snu_pkg::OP_NORM: begin
          c  = w[47:0];
          be = w[59:48];
          if (be[9:0] == 10'o1777) begin
            res.result_word = d;
          end else if (!b.round_enable && c == '0) begin
            res.norm_shift = 6'd48;
          end else begin
            cnt = 0;
            while (cnt < 48 && !c[47]) begin
              c = {c[46:0], (cnt == 0) && b.round_enable};
              cnt++;
            end
            ee = int'(be) - 1024;
            if (ee < 0) ee = ee + 1;
            ee = ee - cnt;
            if (ee < 0) ee = ee - 1;
            ee = ee + 1024;
            res.norm_shift = 6'(cnt);
            if (ee >= 0) res.result_word = {ee[11:0], c} ^ s;
          end
        end
        snu_pkg::OP_MASK: begin
          if (n > 60) n = 6'd60;
          res.result_word = ~(60'hFFF_FFFF_FFFF_FFFF >> n);
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_input(snu_pkg::in_t b);
      awaited.push_back(shifted_result(b));
    endfunction

    function void check_result(snu_pkg::out_t got);
      snu_pkg::out_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing pending: word %h exp %h shift %0d",
                   got.result_word, got.exponent_out, got.norm_shift);
        return;
      end
      want = awaited.pop_front();
      if (got.result_word !== want.result_word || got.exponent_out !== want.exponent_out ||
          got.norm_shift !== want.norm_shift) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want word %h exp %h shift %0d, got word %h exp %h shift %0d",
                   want.result_word, want.exponent_out, want.norm_shift,
                   got.result_word, got.exponent_out, got.norm_shift);
      end
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  snu_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  snu_pkg::out_t out_data;

  shift_result_board board = new;
  bit  long_hold;
  bit  hold_active;
  bit  no_idle;
  int  idle_odds;
  int  cycle_count;

  sixty_bit_shift_normalize_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  function automatic logic [59:0] float_word(bit neg, logic [10:0] bexp, logic [47:0] coef);
    logic [59:0] w;
    w = {1'b0, bexp, coef};
    return neg ? ~w : w;
  endfunction

  function automatic snu_pkg::in_t make_beat(logic [2:0] f, logic [59:0] d, logic [5:0] n,
                                             logic [17:0] e, logic r);
    snu_pkg::in_t b;
    b.func         = f;
    b.data_word    = d;
    b.shift_amount = n;
    b.exponent_in  = e;
    b.round_enable = r;
    return b;
  endfunction

  function automatic snu_pkg::in_t random_beat();
    snu_pkg::in_t b;
    int           pick;
    logic [47:0]  coef;
    logic [10:0]  bexp;
    pick           = $urandom_range(0, 99);
    b.data_word    = 60'({$urandom(), $urandom()});
    b.shift_amount = 6'($urandom_range(0, 63));
    b.exponent_in  = 18'($urandom());
    b.round_enable = 1'($urandom());
    if (pick < 1) b.func = OP_SPARE6;
    else if (pick < 2) b.func = OP_SPARE7;
    else if (pick < 14) b.func = snu_pkg::OP_ROTL;
    else if (pick < 26) b.func = snu_pkg::OP_SRA;
    else if (pick < 38) b.func = snu_pkg::OP_PACK;
    else if (pick < 50) b.func = snu_pkg::OP_UNPACK;
    else if (pick < 58) b.func = snu_pkg::OP_MASK;
    else begin
      b.func = snu_pkg::OP_NORM;
      coef   = 48'({$urandom(), $urandom()}) >> $urandom_range(0, 48);
      case ($urandom_range(0, 9))
        0:       bexp = {1'($urandom()), 10'o1777};
        1:       bexp = 11'($urandom_range(0, 60));
        default: bexp = 11'($urandom());
      endcase
      if ($urandom_range(0, 9) != 0) b.data_word = float_word(1'($urandom()), bexp, coef);
    end
    return b;
  endfunction

  task automatic offer(input snu_pkg::in_t b);
    if (!no_idle && idle_odds != 0 && $urandom_range(0, 9) < idle_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(negedge clk); while (!in_ready);
    board.note_input(b);
    @(posedge clk);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) idle_odds = $urandom_range(0, 3);
      offer(random_beat());
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold   = 1'b0;
        hold_active = 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_odds = 2;
    offer(make_beat(snu_pkg::OP_ROTL, 60'h123_4567_89AB_CDEF, 6'd0, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_ROTL, 60'h800_0000_0000_0001, 6'd1, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_ROTL, 60'h800_0000_0000_0001, 6'd59, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_ROTL, 60'h123_4567_89AB_CDEF, 6'd60, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_ROTL, 60'h123_4567_89AB_CDEF, 6'd63, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_SRA, 60'hF00_0000_0000_0000, 6'd4, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_SRA, 60'h800_0000_0000_0000, 6'd60, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_SRA, 60'h800_0000_0000_0000, 6'd63, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_SRA, 60'h7FF_FFFF_FFFF_FFFF, 6'd61, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_PACK, 60'h000_1234_5678_9ABC, 6'd0, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_PACK, ~60'h000_1234_5678_9ABC, 6'd0, 18'h3FFFF, 1'b1));
    offer(make_beat(snu_pkg::OP_UNPACK, float_word(1'b0, 11'o2005, 48'h8000_0000_0001),
                    6'd0, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_UNPACK, float_word(1'b1, 11'o1770, 48'h1234_5678_9ABC),
                    6'd0, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_UNPACK, 60'hFFF_FFFF_FFFF_FFFF, 6'd0, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_NORM, float_word(1'b0, 11'o3777, 48'h0000_0000_1234),
                    6'd0, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_NORM, float_word(1'b1, 11'o1777, 48'h0000_0000_1234),
                    6'd0, 18'd0, 1'b1));
    offer(make_beat(snu_pkg::OP_NORM, float_word(1'b0, 11'o2000, 48'h0), 6'd0, 18'd0,
                    1'b0));
    offer(make_beat(snu_pkg::OP_NORM, float_word(1'b0, 11'o2000, 48'h0), 6'd0, 18'd0,
                    1'b1));
    offer(make_beat(snu_pkg::OP_NORM, float_word(1'b0, 11'd3, 48'h1), 6'd0, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_NORM, float_word(1'b1, 11'o2010, 48'h0000_0123_4567),
                    6'd0, 18'd0, 1'b1));
    offer(make_beat(snu_pkg::OP_NORM, float_word(1'b0, 11'o1000, 48'h8000_0000_0000),
                    6'd0, 18'd0, 1'b1));
    offer(make_beat(snu_pkg::OP_MASK, 60'd0, 6'd0, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_MASK, 60'd0, 6'd1, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_MASK, 60'd0, 6'd60, 18'd0, 1'b0));
    offer(make_beat(snu_pkg::OP_MASK, 60'd0, 6'd63, 18'd0, 1'b0));
    offer(make_beat(OP_SPARE6, 60'hFFF_FFFF_FFFF_FFFF, 6'd63, 18'h3FFFF, 1'b1));
    offer(make_beat(OP_SPARE7, 60'hFFF_FFFF_FFFF_FFFF, 6'd63, 18'h3FFFF, 1'b1));

    run_random(500);

    // receiver stalls while beats keep coming, so the pipe backs up
    long_hold = 1'b1;
    idle_odds = 0;
    in_valid <= 1'b0;
    while (!hold_active) @(posedge clk);
    for (int i = 0; i < 40; i++) offer(random_beat());

    settle();
    run_random(600);

    no_idle = 1'b1;
    run_random(300);

    settle();
    repeat (8) @(posedge clk);
    if (board.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
sv/snu_pkg.sv
sv/snu_decode.sv
sv/snu_setup.sv
sv/snu_shift.sv
sv/sixty_bit_shift_normalize_unit.sv
dv/tb.sv
